// ===== rtl/dpid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_pkg
// shared types and constants of the dual position servo: transaction
// payloads, configuration register file, lane control and register indexes
// ----------------------------------------------------------------------------
package dpid_pkg;

    // fixed field widths
    localparam int POS_FIELD_W = 24;
    localparam int GAIN_W      = 24;
    localparam int ZONE_W      = 24;
    localparam int DRIVE_W     = 16;
    localparam int INTEG_W     = 56;
    localparam int OUT_FRAC    = 15;
    localparam int Q_LIM_EXP   = 40;

    // lane pipeline depth, arrival flag is known from stage 3 onward
    localparam int NUM_STAGES = 6;
    localparam int ARR_DEPTH  = NUM_STAGES - 2;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7fff;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_KP            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD            = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KF            = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_ZONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DONE_MARGIN   = 3'd7;

    typedef struct packed {
        logic signed [POS_FIELD_W-1:0] left_target;
        logic signed [POS_FIELD_W-1:0] right_target;
        logic signed [POS_FIELD_W-1:0] left_encoder;
        logic signed [POS_FIELD_W-1:0] right_encoder;
    } dpid_in_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      arrived;
    } dpid_out_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic signed [GAIN_W-1:0]  kf;
        logic        [ZONE_W-1:0]  integral_zone;
        logic signed [DRIVE_W-1:0] output_min;
        logic signed [DRIVE_W-1:0] output_max;
        logic        [ZONE_W-1:0]  done_margin;
    } dpid_cfg_t;

    // pipeline control shared by both lanes
    typedef struct packed {
        logic adv;
        logic s2_valid;
        logic s4_valid;
        logic arrived;
    } dpid_ctl_t;

endpackage

// ===== rtl/dual_pid_position_servo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pid_position_servo
// two pid lanes (left, right) with integral zone and feedforward, a shared
// arrival decision and an output register with skid stage
// ----------------------------------------------------------------------------
// path: an accepted input transaction passes lane stages 1 to 6 and then the
//   output register before it shows on out_valid; back-pressure can hold it
// throughput: one transaction per cycle while the skid stage is empty; the
//   integral accumulate loop in each lane closes through a single register
// reset: async active low; clears gains and zone, loads output clamps to
//   full scale and done margin to 64, zeroes integrals and last errors
module dual_pid_position_servo
    import dpid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 20,
    parameter int POSITION_BITS  = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dpid_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dpid_out_t             out_data
);

    dpid_cfg_t                 cfg_reg;
    dpid_ctl_t                 ctl;
    logic                      adv;
    logic                      accept;
    logic                      push;
    logic                      near_l;
    logic                      near_r;
    logic                      arrived;
    logic signed [DRIVE_W-1:0] drive_l;
    logic signed [DRIVE_W-1:0] drive_r;
    dpid_out_t                 result;

    // one valid bit per lane stage, bit 0 is stage 1
    logic [NUM_STAGES-1:0]     vld_reg;
    // arrival flag for stages 3 through 6
    logic [ARR_DEPTH-1:0]      arr_reg;
    logic                      out_valid_reg;
    dpid_out_t                 out_reg;
    logic                      skid_valid_reg;
    dpid_out_t                 skid_reg;

    // configuration register file, to be written only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp            <= '0;
            cfg_reg.ki            <= '0;
            cfg_reg.kd            <= '0;
            cfg_reg.kf            <= '0;
            cfg_reg.integral_zone <= '0;
            cfg_reg.output_min    <= DRIVE_MIN;
            cfg_reg.output_max    <= DRIVE_MAX;
            cfg_reg.done_margin   <= 24'd64;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KP:            cfg_reg.kp            <= signed'(cfg_wdata[GAIN_W-1:0]);
                REG_KI:            cfg_reg.ki            <= signed'(cfg_wdata[GAIN_W-1:0]);
                REG_KD:            cfg_reg.kd            <= signed'(cfg_wdata[GAIN_W-1:0]);
                REG_KF:            cfg_reg.kf            <= signed'(cfg_wdata[GAIN_W-1:0]);
                REG_INTEGRAL_ZONE: cfg_reg.integral_zone <= cfg_wdata[ZONE_W-1:0];
                REG_OUTPUT_MIN:    cfg_reg.output_min    <= signed'(cfg_wdata[DRIVE_W-1:0]);
                REG_OUTPUT_MAX:    cfg_reg.output_max    <= signed'(cfg_wdata[DRIVE_W-1:0]);
                REG_DONE_MARGIN:   cfg_reg.done_margin   <= cfg_wdata[ZONE_W-1:0];
                default:           ;
            endcase
        end
    end

    // the whole lane pipeline moves unless the skid stage holds a result;
    // skid empty guarantees room for whatever leaves stage 6
    assign adv      = !skid_valid_reg;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // merge point: arrival needs both sides inside the margin, decided at
    // stage 2 so the last-error update at stage 3 can be gated by it
    assign arrived = near_l && near_r;

    always_comb
    begin
        ctl.adv      = adv;
        ctl.s2_valid = vld_reg[1];
        ctl.s4_valid = vld_reg[3];
        ctl.arrived  = arrived;
    end

    // left error is target plus position (sensor counts the other way)
    dpid_lane #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .POSITION_BITS  (POSITION_BITS)
    ) u_lane_left (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg          (cfg_reg),
        .sub_position (1'b0),
        .target       (in_data.left_target),
        .position     (in_data.left_encoder),
        .near         (near_l),
        .drive        (drive_l)
    );

    // right error is target minus position
    dpid_lane #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .POSITION_BITS  (POSITION_BITS)
    ) u_lane_right (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg          (cfg_reg),
        .sub_position (1'b1),
        .target       (in_data.right_target),
        .position     (in_data.right_encoder),
        .near         (near_r),
        .drive        (drive_r)
    );

    always_comb
    begin
        result.left_drive  = drive_l;
        result.right_drive = drive_r;
        result.arrived     = arr_reg[ARR_DEPTH-1];
    end

    // a finished transaction leaves stage 6 on this edge
    assign push = adv && vld_reg[NUM_STAGES-1];

    // control: stage valids, output and skid occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[NUM_STAGES-2:0], accept};

            if (skid_valid_reg)
            begin
                // skid drains into the output register, which stays full
                if (out_ready)
                    skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                if (!out_valid_reg || out_ready)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: arrival pipe, output register, skid register
    always_ff @(posedge clk)
    begin
        if (adv)
            arr_reg <= {arr_reg[ARR_DEPTH-2:0], arrived};

        if (skid_valid_reg)
        begin
            if (out_ready)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
                out_reg <= result;
            else
                skid_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/dpid_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_lane
// one pid side: error, arrival and zone flags, gain products, saturating
// integral, q1.15 scaling, clamp and negated drive
// ----------------------------------------------------------------------------
module dpid_lane
    import dpid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 20,
    parameter int POSITION_BITS  = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dpid_ctl_t                     ctl,
    input  dpid_cfg_t                     cfg,
    input  logic                          sub_position,
    input  logic signed [POS_FIELD_W-1:0] target,
    input  logic signed [POS_FIELD_W-1:0] position,
    output logic                          near,
    output logic signed [DRIVE_W-1:0]     drive
);

    localparam int EW  = POSITION_BITS + 1;
    localparam int DFW = EW + 1;
    localparam int CW  = (EW > ZONE_W) ? EW : ZONE_W;
    localparam int PW  = GAIN_W + EW;
    localparam int DW  = GAIN_W + DFW;
    localparam int IAW = ((INTEG_W > PW) ? INTEG_W : PW) + 1;
    localparam int PSW = DW + 2;
    localparam int SW  = ((INTEG_W > PSW) ? INTEG_W : PSW) + 1;

    localparam logic signed [IAW-1:0] I_MAX = IAW'({1'b0, {(INTEG_W-1){1'b1}}});
    localparam logic signed [IAW-1:0] I_MIN = ~I_MAX;

    logic signed [EW-1:0]      tgt_x;
    logic signed [EW-1:0]      pos_x;
    logic signed [EW-1:0]      err_next;
    logic        [EW-1:0]      mag;
    logic                      near_next;
    logic                      inz_next;
    logic signed [DFW-1:0]     diff_next;
    logic signed [IAW-1:0]     integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [SW-1:0]      sum;
    logic signed [SW-1:0]      scaled_next;
    logic signed [SW-1:0]      omin_x;
    logic signed [SW-1:0]      omax_x;
    logic signed [SW-1:0]      lo_clamped;
    logic signed [SW-1:0]      clamped;
    logic signed [DRIVE_W-1:0] v16;

    // stage registers
    logic signed [EW-1:0]      err_s1_reg, tgt_s1_reg;
    logic signed [EW-1:0]      err_s2_reg, tgt_s2_reg;
    logic                      near_s2_reg, inz_s2_reg;
    logic signed [EW-1:0]      err_s3_reg, tgt_s3_reg;
    logic signed [DFW-1:0]     diff_s3_reg;
    logic                      inz_s3_reg, arr_s3_reg;
    logic signed [PW-1:0]      pp_s4_reg, pi_s4_reg, pf_s4_reg;
    logic signed [DW-1:0]      pd_s4_reg;
    logic                      inz_s4_reg, arr_s4_reg;
    logic signed [INTEG_W-1:0] integ_s5_reg;
    logic signed [PSW-1:0]     psum_s5_reg;
    logic                      arr_s5_reg;
    logic signed [SW-1:0]      scaled_s6_reg;
    logic                      arr_s6_reg;

    // loop state
    logic signed [EW-1:0]      last_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    // low POSITION_BITS of the field taken as signed; a wider POSITION_BITS zero-extends the field
    if (POSITION_BITS <= POS_FIELD_W) begin : g_sext
        assign tgt_x = EW'(signed'(target[POSITION_BITS-1:0]));
        assign pos_x = EW'(signed'(position[POSITION_BITS-1:0]));
    end else begin : g_zext
        assign tgt_x = EW'({1'b0, target});
        assign pos_x = EW'({1'b0, position});
    end

    assign err_next = sub_position ? (tgt_x - pos_x) : (tgt_x + pos_x);

    always_comb
    begin
        mag       = err_s1_reg[EW-1] ? EW'(-err_s1_reg) : EW'(err_s1_reg);
        near_next = CW'(mag) < CW'(cfg.done_margin);
        inz_next  = (cfg.integral_zone == '0) || (CW'(mag) <= CW'(cfg.integral_zone));
        diff_next = DFW'(err_s2_reg) - DFW'(last_reg);
    end

    // integral: saturating accumulate inside the zone, cleared outside
    always_comb
    begin
        integ_sum = IAW'(integ_reg) + IAW'(pi_s4_reg);
        if (integ_sum > I_MAX)
            integ_sat = I_MAX[INTEG_W-1:0];
        else if (integ_sum < I_MIN)
            integ_sat = I_MIN[INTEG_W-1:0];
        else
            integ_sat = integ_sum[INTEG_W-1:0];
        integ_new = inz_s4_reg ? integ_sat : '0;
    end

    assign sum = SW'(psum_s5_reg) + SW'(integ_s5_reg);

    // scaling to q1.15, floor rounding on a right shift; a left shift limits the sum first
    if (GAIN_FRAC_BITS >= OUT_FRAC) begin : g_shr
        assign scaled_next = sum >>> (GAIN_FRAC_BITS - OUT_FRAC);
    end else begin : g_shl
        localparam logic signed [SW-1:0] Q_LIM = SW'(1) <<< Q_LIM_EXP;
        logic signed [SW-1:0] limited;
        always_comb
        begin
            if (sum > Q_LIM)
                limited = Q_LIM;
            else if (sum < -Q_LIM)
                limited = -Q_LIM;
            else
                limited = sum;
            scaled_next = limited <<< (OUT_FRAC - GAIN_FRAC_BITS);
        end
    end

    // clamp: min first, max wins when bounds cross; then zero if arrived, else negate with saturation
    always_comb
    begin
        omin_x     = SW'(cfg.output_min);
        omax_x     = SW'(cfg.output_max);
        lo_clamped = (scaled_s6_reg < omin_x) ? omin_x : scaled_s6_reg;
        clamped    = (lo_clamped > omax_x) ? omax_x : lo_clamped;
        v16        = clamped[DRIVE_W-1:0];
        if (arr_s6_reg)
            drive = '0;
        else if (v16 == DRIVE_MIN)
            drive = DRIVE_MAX;
        else
            drive = -v16;
    end

    assign near = near_s2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            err_s1_reg    <= err_next;
            tgt_s1_reg    <= tgt_x;

            err_s2_reg    <= err_s1_reg;
            tgt_s2_reg    <= tgt_s1_reg;
            near_s2_reg   <= near_next;
            inz_s2_reg    <= inz_next;

            err_s3_reg    <= err_s2_reg;
            tgt_s3_reg    <= tgt_s2_reg;
            diff_s3_reg   <= diff_next;
            inz_s3_reg    <= inz_s2_reg;
            arr_s3_reg    <= ctl.arrived;

            pp_s4_reg     <= PW'(cfg.kp) * PW'(err_s3_reg);
            pi_s4_reg     <= PW'(cfg.ki) * PW'(err_s3_reg);
            pf_s4_reg     <= PW'(cfg.kf) * PW'(tgt_s3_reg);
            pd_s4_reg     <= DW'(cfg.kd) * DW'(diff_s3_reg);
            inz_s4_reg    <= inz_s3_reg;
            arr_s4_reg    <= arr_s3_reg;

            integ_s5_reg  <= integ_new;
            psum_s5_reg   <= PSW'(pp_s4_reg) + PSW'(pd_s4_reg) + PSW'(pf_s4_reg);
            arr_s5_reg    <= arr_s4_reg;

            scaled_s6_reg <= scaled_next;
            arr_s6_reg    <= arr_s5_reg;
        end
    end

    // state moves only for samples that are not arrived
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            integ_reg <= '0;
        end
        else
        begin
            if (ctl.adv && ctl.s2_valid && !ctl.arrived)
                last_reg <= err_s2_reg;
            if (ctl.adv && ctl.s4_valid && !arr_s4_reg)
                integ_reg <= integ_new;
        end
    end

endmodule

// ===== rtl/dpid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_checker
// port-level checks of the dual position servo, bound to the top level
// ----------------------------------------------------------------------------
module dpid_checker
    import dpid_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input dpid_out_t             out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // arrived transactions carry zero drives
    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.arrived |-> out_data.left_drive == '0
                                          && out_data.right_drive == '0)
        else $error("nonzero drive on arrived result");

    // input stalls only behind a pending result
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // input stalls only after the output was blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // negation saturates, full-scale negative never appears
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.left_drive != DRIVE_MIN
                      && out_data.right_drive != DRIVE_MIN)
        else $error("drive at negative full scale");

endmodule

bind dual_pid_position_servo dpid_checker u_dpid_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dual position servo: every input transaction
// accepted by the block is run through a local copy of both pid lanes, and
// each result transaction is compared field by field with the oldest
// predicted drive pair. directed corner tests come first, then random
// stimulus under three handshake idling profiles.
// ----------------------------------------------------------------------------
module tb;
    import dpid_pkg::*;

    localparam int     GAIN_FRAC   = 20;
    localparam int     LATENCY     = 6;     // extra wait after the pending results drain
    localparam int     STALL_LIMIT = 2000;  // cycles with no transaction on either side
    localparam int     MAX_REPORTS = 10;
    localparam int     SAT_ITEMS   = 264;   // just past the 256 full-error steps to the limit
    localparam longint INTEG_HI    = (64'sd1 <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO    = -INTEG_HI - 1;

    localparam logic signed [POS_FIELD_W-1:0] POS_MAX  = 24'sh7fffff;
    localparam logic signed [POS_FIELD_W-1:0] POS_MIN  = 24'sh800000;
    localparam logic signed [GAIN_W-1:0]      GAIN_MAX = 24'sh7fffff;
    localparam logic signed [GAIN_W-1:0]      GAIN_MIN = 24'sh800000;
    localparam logic        [ZONE_W-1:0]      ZONE_MAX = 24'hffffff;

    // dut ports, all inputs known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    dpid_in_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    dpid_out_t             out_data;

    // local copy of the servo registers and lane state
    dpid_cfg_t servo_cfg;
    longint    left_integ;
    longint    right_integ;
    longint    left_last_err;
    longint    right_last_err;

    // predicted drive pairs, oldest first
    dpid_out_t pending_drives[$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    dual_pid_position_servo u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // receiver back-pressure, one decision per cycle at the falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // servo prediction
    // ------------------------------------------------------------------
    function automatic longint magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // one pid lane: integrate inside the zone, sum the four terms, scale to
    // q1.15 with floor rounding, clamp and negate
    function automatic logic [DRIVE_W-1:0] lane_drive(input longint target,
                                                      input longint err,
                                                      inout longint integ,
                                                      inout longint last);
        longint kp;
        longint ki;
        longint kd;
        longint kf;
        longint zone;
        longint lo;
        longint hi;
        longint acc;
        longint v;
        kp   = longint'($signed(servo_cfg.kp));
        ki   = longint'($signed(servo_cfg.ki));
        kd   = longint'($signed(servo_cfg.kd));
        kf   = longint'($signed(servo_cfg.kf));
        zone = servo_cfg.integral_zone;
        lo   = longint'($signed(servo_cfg.output_min));
        hi   = longint'($signed(servo_cfg.output_max));

        // zero zone means the integral always runs
        if (zone == 0 || magnitude(err) <= zone)
        begin
            acc = integ + err * ki;
            if (acc > INTEG_HI)
                acc = INTEG_HI;
            else if (acc < INTEG_LO)
                acc = INTEG_LO;
            integ = acc;
        end
        else
            integ = 0;

        acc  = kp * err + integ + kd * (err - last) + kf * target;
        last = err;

        // arithmetic shift of a signed value rounds toward minus infinity
        v = acc >>> (GAIN_FRAC - OUT_FRAC);
        // raise to min first, so max wins when the bounds cross
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        v = -v;
        if (v > 32767)
            v = 32767;
        return v[DRIVE_W-1:0];
    endfunction

    function automatic dpid_out_t servo_predict(input dpid_in_t d);
        dpid_out_t r;
        longint    lt;
        longint    rt;
        longint    lp;
        longint    rp;
        longint    le;
        longint    re;
        longint    margin;
        lt     = longint'($signed(d.left_target));
        rt     = longint'($signed(d.right_target));
        lp     = longint'($signed(d.left_encoder));
        rp     = longint'($signed(d.right_encoder));
        // left encoder counts the other way round
        le     = lt + lp;
        re     = rt - rp;
        margin = servo_cfg.done_margin;
        r      = '0;
        if (magnitude(le) < margin && magnitude(re) < margin)
            r.arrived = 1'b1;  // lane state left untouched
        else
        begin
            r.left_drive  = lane_drive(lt, le, left_integ, left_last_err);
            r.right_drive = lane_drive(rt, re, right_integ, right_last_err);
        end
        return r;
    endfunction

    function automatic void servo_reset();
        servo_cfg             = '0;
        servo_cfg.output_min  = DRIVE_MIN;
        servo_cfg.output_max  = DRIVE_MAX;
        servo_cfg.done_margin = 24'd64;
        left_integ            = 0;
        right_integ           = 0;
        left_last_err         = 0;
        right_last_err        = 0;
    endfunction

    // ------------------------------------------------------------------
    // builders for configurations and input transactions
    // ------------------------------------------------------------------
    function automatic dpid_cfg_t make_config(input logic signed [GAIN_W-1:0]  kp,
                                              input logic signed [GAIN_W-1:0]  ki,
                                              input logic signed [GAIN_W-1:0]  kd,
                                              input logic signed [GAIN_W-1:0]  kf,
                                              input logic        [ZONE_W-1:0]  zone,
                                              input logic signed [DRIVE_W-1:0] lo,
                                              input logic signed [DRIVE_W-1:0] hi,
                                              input logic        [ZONE_W-1:0]  margin);
        dpid_cfg_t c;
        c.kp            = kp;
        c.ki            = ki;
        c.kd            = kd;
        c.kf            = kf;
        c.integral_zone = zone;
        c.output_min    = lo;
        c.output_max    = hi;
        c.done_margin   = margin;
        return c;
    endfunction

    function automatic dpid_in_t make_item(input logic signed [POS_FIELD_W-1:0] lt,
                                           input logic signed [POS_FIELD_W-1:0] rt,
                                           input logic signed [POS_FIELD_W-1:0] lp,
                                           input logic signed [POS_FIELD_W-1:0] rp);
        dpid_in_t d;
        d.left_target   = lt;
        d.right_target  = rt;
        d.left_encoder  = lp;
        d.right_encoder = rp;
        return d;
    endfunction

    // random 24 bit value with a random magnitude, so small numbers are common
    function automatic logic signed [POS_FIELD_W-1:0] rand_scaled();
        logic signed [POS_FIELD_W-1:0] r;
        r = POS_FIELD_W'($urandom);
        return r >>> $urandom_range(0, POS_FIELD_W - 1);
    endfunction

    function automatic dpid_cfg_t random_config();
        dpid_cfg_t                 c;
        logic signed [DRIVE_W-1:0] swap;
        c.kp = rand_scaled();
        c.ki = rand_scaled();
        c.kd = rand_scaled();
        c.kf = rand_scaled();
        case ($urandom_range(0, 2))
            0:       c.integral_zone = '0;
            1:       c.integral_zone = ZONE_W'($urandom_range(1, 5000));
            default: c.integral_zone = ZONE_W'($urandom);
        endcase
        c.output_min = DRIVE_W'($urandom);
        c.output_max = DRIVE_W'($urandom);
        // crossed clamp bounds are kept now and then
        if ($urandom_range(0, 4) != 0 && $signed(c.output_min) > $signed(c.output_max))
        begin
            swap         = c.output_min;
            c.output_min = c.output_max;
            c.output_max = swap;
        end
        case ($urandom_range(0, 3))
            0:       c.done_margin = '0;
            1:       c.done_margin = ZONE_W'($urandom_range(1, 2000));
            2:       c.done_margin = ZONE_W'($urandom_range(1, 200));
            default: c.done_margin = ZONE_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic dpid_cfg_t extreme_config(input int pick);
        case (pick)
            0:       return make_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, ZONE_MAX,
                                        DRIVE_MIN, DRIVE_MAX, '0);
            1:       return make_config(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, '0,
                                        DRIVE_MAX, DRIVE_MIN, 24'd1);
            2:       return make_config('0, '0, '0, GAIN_MAX, 24'd1,
                                        '0, '0, ZONE_MAX);
            default: return make_config(rand_scaled(), rand_scaled(), rand_scaled(),
                                        rand_scaled(), ZONE_W'($urandom_range(0, 300)),
                                        DRIVE_MIN, DRIVE_MIN, '0);
        endcase
    endfunction

    // mix of samples near arrival, small tracking errors and wide random ones
    function automatic dpid_in_t rand_item();
        dpid_in_t d;
        longint   span;
        longint   ldelta;
        longint   rdelta;
        d.left_target  = rand_scaled();
        d.right_target = rand_scaled();
        span = servo_cfg.done_margin;
        if (span > 4096)
            span = 4096;
        span = span + 2;
        case ($urandom_range(0, 3))
            0:
            begin
                ldelta = longint'($urandom_range(0, int'(2 * span))) - span;
                rdelta = longint'($urandom_range(0, int'(2 * span))) - span;
            end
            1:
            begin
                ldelta = longint'($signed(rand_scaled() >>> 8));
                rdelta = longint'($signed(rand_scaled() >>> 8));
            end
            default:
            begin
                ldelta = longint'($signed(rand_scaled()));
                rdelta = longint'($signed(rand_scaled()));
            end
        endcase
        // left error is target plus position, right is target minus position
        d.left_encoder  = POS_FIELD_W'(ldelta - longint'($signed(d.left_target)));
        d.right_encoder = POS_FIELD_W'(longint'($signed(d.right_target)) - rdelta);
        return d;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one input transaction, with a random gap of idle cycles before it
    task automatic send_item(input dpid_in_t d);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 50)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge: advance the local servo copy
        pending_drives.push_back(servo_predict(d));
    endtask

    // sender pauses until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            REG_KP:            servo_cfg.kp            = value;
            REG_KI:            servo_cfg.ki            = value;
            REG_KD:            servo_cfg.kd            = value;
            REG_KF:            servo_cfg.kf            = value;
            REG_INTEGRAL_ZONE: servo_cfg.integral_zone = value;
            REG_OUTPUT_MIN:    servo_cfg.output_min    = value[DRIVE_W-1:0];
            REG_OUTPUT_MAX:    servo_cfg.output_max    = value[DRIVE_W-1:0];
            REG_DONE_MARGIN:   servo_cfg.done_margin   = value;
            default:           ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // full register load, only once the block has gone quiet
    task automatic load_config(input dpid_cfg_t c);
        drain_results();
        write_reg(REG_KP, c.kp);
        write_reg(REG_KI, c.ki);
        write_reg(REG_KD, c.kd);
        write_reg(REG_KF, c.kf);
        write_reg(REG_INTEGRAL_ZONE, c.integral_zone);
        write_reg(REG_OUTPUT_MIN, {{(CFG_DATA_W - DRIVE_W){c.output_min[DRIVE_W-1]}},
                                   c.output_min});
        write_reg(REG_OUTPUT_MAX, {{(CFG_DATA_W - DRIVE_W){c.output_max[DRIVE_W-1]}},
                                   c.output_max});
        write_reg(REG_DONE_MARGIN, c.done_margin);
    endtask

    // ------------------------------------------------------------------
    // result checker: compare each result transaction with the oldest
    // prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dpid_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_drives.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: left %0d right %0d arrived %0b",
                             $signed(out_data.left_drive), $signed(out_data.right_drive),
                             out_data.arrived);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (out_data.left_drive !== want.left_drive ||
                    out_data.right_drive !== want.right_drive ||
                    out_data.arrived !== want.arrived)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: left %0d/%0d right %0d/%0d arrived %0b/%0b",
                                 $signed(want.left_drive), $signed(out_data.left_drive),
                                 $signed(want.right_drive), $signed(out_data.right_drive),
                                 want.arrived, out_data.arrived);
                end
            end
        end
    end

    // watchdog: too long without a transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("dual_pid_position_servo test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: zero gains, full clamps, done margin of 64
    task automatic test_reset_values();
        send_item(make_item('0, '0, '0, '0));
        send_item(make_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_item(make_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN));
        // margin edge: 63 is inside, 64 is not
        send_item(make_item(24'sd63, '0, '0, 24'sd63));
        send_item(make_item('0, '0, -24'sd64, '0));
        send_item(make_item('0, 24'sd1, '0, 24'sd65));
        drain_results();
    endtask

    task automatic test_field_extremes();
        load_config(make_config(GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MIN, ZONE_MAX,
                                DRIVE_MIN, DRIVE_MAX, '0));
        send_item(make_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_item(make_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN));
        send_item(make_item(POS_MAX, POS_MIN, POS_MIN, POS_MAX));
        send_item(make_item(POS_MIN, POS_MAX, POS_MAX, POS_MIN));

        // crossed clamp bounds: max wins
        load_config(make_config(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, 24'd1,
                                16'sd1000, -16'sd1000, 24'd1));
        send_item(make_item(24'sd5, -24'sd7, 24'sd3, 24'sd9));
        send_item(make_item(POS_MAX, POS_MIN, '0, '0));
        send_item(make_item(POS_MIN, POS_MAX, '0, '0));

        // output pinned at -32768, negation saturates to 32767
        load_config(make_config(GAIN_MAX, '0, '0, '0, '0, DRIVE_MIN, DRIVE_MAX, '0));
        send_item(make_item(POS_MIN, POS_MAX, POS_MIN, POS_MIN));

        // widest done margin: only the most negative left error and the widest right errors get out
        load_config(make_config(GAIN_MAX, '0, '0, '0, '0, DRIVE_MIN, DRIVE_MAX, ZONE_MAX));
        send_item(make_item(POS_MAX, POS_MAX, POS_MAX, POS_MIN + 24'sd1));
        send_item(make_item(POS_MIN, '0, POS_MIN, '0));
    endtask

    // kp of one lsb makes the scaling shift visible on tiny errors
    task automatic test_floor_rounding();
        load_config(make_config(24'sd1, '0, '0, '0, '0, DRIVE_MIN, DRIVE_MAX, '0));
        send_item(make_item(-24'sd1, 24'sd1, '0, '0));
        send_item(make_item(-24'sd33, 24'sd33, '0, '0));
        send_item(make_item('0, '0, -24'sd32, 24'sd32));
    endtask

    // ki of 32 integrates one output lsb per tick of error
    task automatic test_integral_zone();
        load_config(make_config('0, 24'sd32, '0, '0, 24'd100, DRIVE_MIN, DRIVE_MAX, '0));
        send_item(make_item(24'sd50, 24'sd20, '0, '0));
        send_item(make_item(24'sd100, '0, '0, 24'sd100));
        drain_results();
        // just outside the zone clears the integral
        send_item(make_item(24'sd101, '0, '0, -24'sd101));
        send_item(make_item(-24'sd100, 24'sd100, '0, '0));
        send_item(make_item('0, '0, -24'sd101, 24'sd101));
        send_item(make_item(24'sd30, -24'sd30, '0, '0));
    endtask

    // drive the left integral into positive and the right one into negative
    // saturation, then turn both around; a wrapped integral flips the drive
    task automatic test_integral_saturation();
        int i;
        // start from a cleared integral
        load_config(make_config('0, GAIN_MAX, '0, '0, 24'd1, DRIVE_MIN, DRIVE_MAX, '0));
        send_item(make_item(POS_MAX, POS_MAX, POS_MAX, POS_MIN));
        load_config(make_config('0, GAIN_MAX, '0, '0, '0, DRIVE_MIN, DRIVE_MAX, '0));
        for (i = 0; i < SAT_ITEMS; i++)
            send_item(make_item(POS_MAX, POS_MIN, POS_MAX, POS_MAX));
        for (i = 0; i < SAT_ITEMS / 8; i++)
            send_item(make_item(POS_MIN, POS_MAX, POS_MIN, POS_MIN));
    endtask

    // random samples, with a fresh register set every forty transactions
    task automatic test_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    load_config(extreme_config($urandom_range(0, 3)));
                else
                    load_config(random_config());
            end
            send_item(rand_item());
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        servo_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 20;
        recv_idle_pct = 46;
        test_reset_values();
        test_field_extremes();
        test_floor_rounding();
        test_integral_zone();
        test_integral_saturation();
        test_random(100);

        // roles swapped
        send_idle_pct = 46;
        recv_idle_pct = 20;
        test_random(100);

        // back to back, no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(100);

        drain_results();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_drives.size() == 0)
            $display("dual_pid_position_servo test passed");
        else
            $display("dual_pid_position_servo test failed");
        $finish;
    end

endmodule
